FILE: design/kwm_pkg.sv
package kwm_pkg;

  // Segment organization
  localparam int MAX_SEGMENTS = 8;
  localparam int SEG_DEPTH    = 1024;

  localparam int SEG_W   = $clog2(MAX_SEGMENTS);
  localparam int DEPTH_W = $clog2(SEG_DEPTH);
  localparam int CNT_W   = DEPTH_W + 1;
  localparam int ADDR_W  = SEG_W + DEPTH_W;
  localparam int LIM_W   = 4;
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [LIM_W-1:0] ACTIVE_RESET = LIM_W'(8);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_INACTIVE = 2'd2;

endpackage

FILE: design/kway_merge_min_scan.sv
// A load, clear or unused command goes from S_IDLE to S_DONE; a pop scans the N active
// segments (N at most 8) in S_SCAN, then goes through S_LAST to S_DONE, where a result waits
// while the output stalls. No input beat is taken outside S_IDLE; the pop time is set by the
// single head comparator, fed one segment per cycle from the one read port of the store.
// Reset (rst_n low, synchronous): fill counts and read indices clear, active count is 8;
// the value store is not cleared, only entries below a fill count are ever used.
module kway_merge_min_scan
  import kwm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input beats
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [SEG_W-1:0]         in_segment,
  input  logic signed [DATA_W-1:0] in_value,
  // result beats
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value,
  output logic [SEG_W-1:0]         out_segment,
  output logic                     out_valid_res,
  output logic                     out_drained,
  output logic [STAT_W-1:0]        out_status,
  // active segment count register
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LIM_W-1:0]         cfg_active_segments
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST, S_DONE} state_t;

  state_t                   state_r, state_nxt;
  logic [LIM_W-1:0]         active_r;
  logic [CNT_W-1:0]         fill_r  [MAX_SEGMENTS];
  logic [CNT_W-1:0]         rdidx_r [MAX_SEGMENTS];
  logic [LIM_W-1:0]         scan_r, scan_nxt;
  logic                     pend_vld_r, pend_vld_nxt;
  logic [SEG_W-1:0]         pend_seg_r, pend_seg_nxt;
  logic                     found_r, found_nxt;
  logic signed [DATA_W-1:0] best_r, best_nxt;
  logic [SEG_W-1:0]         best_seg_r, best_seg_nxt;
  logic [CMD_W-1:0]         cmd_r, cmd_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [SEG_W-1:0]         out_segment_r, out_segment_nxt;
  logic                     out_vres_r, out_vres_nxt;
  logic                     out_drained_r, out_drained_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;

  // value store, one write and one registered read port
  logic signed [DATA_W-1:0] mem [MAX_SEGMENTS*SEG_DEPTH];
  logic signed [DATA_W-1:0] mem_q;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic                     mem_we;

  logic [LIM_W-1:0] limit;
  logic             in_acc, slot_free, seg_ok, seg_full;
  logic [SEG_W-1:0] scan_seg;
  logic             scan_on, head_ok;
  logic             clear_en, pop_adv;

  // handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign slot_free = ~out_valid_r | ~out_stall;
  assign cfg_ready = 1'b1;

  // active limit, clipped to the segment count
  assign limit = (active_r > LIM_W'(MAX_SEGMENTS)) ? LIM_W'(MAX_SEGMENTS) : active_r;

  // load checks
  assign seg_ok    = {{(LIM_W-SEG_W){1'b0}}, in_segment} < limit;
  assign seg_full  = fill_r[in_segment] >= CNT_W'(SEG_DEPTH);
  assign mem_we    = in_acc & (in_command == CMD_LOAD) & seg_ok & ~seg_full;
  assign mem_waddr = {in_segment, fill_r[in_segment][DEPTH_W-1:0]};

  // scan: one segment head read per cycle
  assign scan_seg  = scan_r[SEG_W-1:0];
  assign scan_on   = scan_r < limit;
  assign head_ok   = rdidx_r[scan_seg] < fill_r[scan_seg];
  assign mem_raddr = {scan_seg, rdidx_r[scan_seg][DEPTH_W-1:0]};

  assign clear_en = in_acc & (in_command == CMD_CLEAR);
  assign pop_adv  = (state_r == S_DONE) & slot_free & (cmd_r == CMD_POP) & found_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_value;
    end
    mem_q <= mem[mem_raddr];
  end

  // sequencer and shared comparator
  always_comb begin
    state_nxt       = state_r;
    scan_nxt        = scan_r;
    pend_vld_nxt    = 1'b0;
    pend_seg_nxt    = scan_seg;
    found_nxt       = found_r;
    best_nxt        = best_r;
    best_seg_nxt    = best_seg_r;
    cmd_nxt         = cmd_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r & out_stall;
    out_value_nxt   = out_value_r;
    out_segment_nxt = out_segment_r;
    out_vres_nxt    = out_vres_r;
    out_drained_nxt = out_drained_r;
    out_status_nxt  = out_status_r;

    // compare the head read last cycle against the running minimum
    if (pend_vld_r && (!found_r || (mem_q < best_r))) begin
      found_nxt    = 1'b1;
      best_nxt     = mem_q;
      best_seg_nxt = pend_seg_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_command;
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          scan_nxt   = '0;
          if (in_command == CMD_LOAD) begin
            if (!seg_ok) begin
              status_nxt = ST_INACTIVE;
            end else if (seg_full) begin
              status_nxt = ST_FULL;
            end
          end
          state_nxt = (in_command == CMD_POP) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_on) begin
          pend_vld_nxt = head_ok;
          scan_nxt     = scan_r + LIM_W'(1);
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_value_nxt   = '0;
          out_segment_nxt = '0;
          out_vres_nxt    = 1'b0;
          out_drained_nxt = 1'b0;
          out_status_nxt  = ST_OK;
          case (cmd_r)
            CMD_POP: begin
              if (found_r) begin
                out_value_nxt   = best_r;
                out_segment_nxt = best_seg_r;
                out_vres_nxt    = 1'b1;
              end else begin
                out_drained_nxt = 1'b1;
              end
            end
            CMD_LOAD: out_status_nxt = status_r;
            default:  out_status_nxt = ST_OK;
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      active_r      <= ACTIVE_RESET;
      scan_r        <= '0;
      pend_vld_r    <= 1'b0;
      pend_seg_r    <= '0;
      found_r       <= 1'b0;
      best_r        <= '0;
      best_seg_r    <= '0;
      cmd_r         <= CMD_LOAD;
      status_r      <= ST_OK;
      out_valid_r   <= 1'b0;
      out_value_r   <= '0;
      out_segment_r <= '0;
      out_vres_r    <= 1'b0;
      out_drained_r <= 1'b0;
      out_status_r  <= ST_OK;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        fill_r[i]  <= '0;
        rdidx_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      scan_r        <= scan_nxt;
      pend_vld_r    <= pend_vld_nxt;
      pend_seg_r    <= pend_seg_nxt;
      found_r       <= found_nxt;
      best_r        <= best_nxt;
      best_seg_r    <= best_seg_nxt;
      cmd_r         <= cmd_nxt;
      status_r      <= status_nxt;
      out_valid_r   <= out_valid_nxt;
      out_value_r   <= out_value_nxt;
      out_segment_r <= out_segment_nxt;
      out_vres_r    <= out_vres_nxt;
      out_drained_r <= out_drained_nxt;
      out_status_r  <= out_status_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_active_segments;
      end
      // segment bookkeeping
      if (clear_en) begin
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
          fill_r[i]  <= '0;
          rdidx_r[i] <= '0;
        end
      end else begin
        if (mem_we) begin
          fill_r[in_segment] <= fill_r[in_segment] + CNT_W'(1);
        end
        if (pop_adv) begin
          rdidx_r[best_seg_r] <= rdidx_r[best_seg_r] + CNT_W'(1);
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_segment   = out_segment_r;
  assign out_valid_res = out_vres_r;
  assign out_drained   = out_drained_r;
  assign out_status    = out_status_r;

endmodule

FILE: design/kwm_checker.sv
module kwm_checker
  import kwm_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_value,
  input logic [SEG_W-1:0]         out_segment,
  input logic                     out_valid_res,
  input logic                     out_drained,
  input logic [STAT_W-1:0]        out_status
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // one item at a time: the block is busy right after an input beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // a popped value carries no drained flag and no load status
  a_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> !out_drained && (out_status == ST_OK))
    else $error("popped value with drained or status set");

  // drained and dropped-load beats carry zero payload
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_drained || (out_status != ST_OK))
      |-> (out_value == '0) && (out_segment == '0) && !out_valid_res)
    else $error("payload not zero on drained or dropped beat");

endmodule

bind kway_merge_min_scan kwm_checker u_kwm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value     (out_value),
  .out_segment   (out_segment),
  .out_valid_res (out_valid_res),
  .out_drained   (out_drained),
  .out_status    (out_status)
);
